// File: hdl/utf8_to_cp1250_transcoder_top_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 to CP1250 transcoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP1250_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_CP1250_TRANSCODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U2C_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/u2c_pkg.sv
// ----------------------------------------------------------------------------
// u2c_pkg
// Codes and the fixed sequence-to-CP1250 mapping table of the transcoder.
// ----------------------------------------------------------------------------
package u2c_pkg;

  // Terminator stop reasons.
  localparam logic [1:0] STOP_INPUT_ZERO = 2'd0;
  localparam logic [1:0] STOP_UNMAPPED   = 2'd1;
  localparam logic [1:0] STOP_LIMIT      = 2'd2;

  // Number of buffered sequence bytes.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_LEAD = 2'd1;
  localparam logic [1:0] PEND_MID  = 2'd2;

  // Table row selected by the byte preceding the suffix.
  localparam logic [3:0] ROW_C2     = 4'd0;
  localparam logic [3:0] ROW_C3     = 4'd1;
  localparam logic [3:0] ROW_C4     = 4'd2;
  localparam logic [3:0] ROW_C5     = 4'd3;
  localparam logic [3:0] ROW_CB     = 4'd4;
  localparam logic [3:0] ROW_E2_80  = 4'd5;
  localparam logic [3:0] ROW_E2_82  = 4'd6;
  localparam logic [3:0] ROW_E2_84  = 4'd7;
  localparam logic [3:0] ROW_C8     = 4'd8;
  localparam logic [3:0] ROW_NONE   = 4'd15;

  localparam logic [7:0] LEAD_E2 = 8'hE2;

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b >= 8'hC2 && b <= 8'hC5) || b == 8'hC8 || b == 8'hCB || b == LEAD_E2;
  endfunction

  function automatic logic middle_ok(input logic [7:0] b);
    middle_ok = b == 8'h80 || b == 8'h82 || b == 8'h84;
  endfunction

  // The middle bytes select the three-byte rows; the state guarantees that a
  // lookup keyed by a middle byte is only used after an E2 lead.
  function automatic logic [3:0] row_of(input logic [7:0] b);
    logic [3:0] r;
    case (b)
      8'hC2: r = ROW_C2;
      8'hC3: r = ROW_C3;
      8'hC4: r = ROW_C4;
      8'hC5: r = ROW_C5;
      8'hCB: r = ROW_CB;
      8'h80: r = ROW_E2_80;
      8'h82: r = ROW_E2_82;
      8'h84: r = ROW_E2_84;
      8'hC8: r = ROW_C8;
      default: r = ROW_NONE;
    endcase
    row_of = r;
  endfunction

  // Returns the CP1250 byte, or zero when the sequence is not in the table.
  function automatic logic [7:0] cp_map(input logic [3:0] row, input logic [7:0] s);
    logic [7:0] m;
    m = 8'h00;
    case (row)
      ROW_C2: begin
        case (s)
          8'h81, 8'h83, 8'h88, 8'h90, 8'h98, 8'hA0, 8'hA4, 8'hA6, 8'hA7, 8'hA8,
          8'hA9, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hB0, 8'hB1, 8'hB4, 8'hB5, 8'hB6,
          8'hB7, 8'hB8, 8'hBB: m = s;
          default: m = 8'h00;
        endcase
      end
      ROW_C3: begin
        case (s)
          8'h81, 8'h82, 8'h84, 8'h87, 8'h89, 8'h8B, 8'h8D, 8'h8E, 8'h93, 8'h94,
          8'h96, 8'h97, 8'h9A, 8'h9C, 8'h9D, 8'h9F, 8'hA1, 8'hA2, 8'hA4, 8'hA7,
          8'hA9, 8'hAB, 8'hAD, 8'hAE, 8'hB3, 8'hB4, 8'hB6, 8'hB7, 8'hBA, 8'hBC,
          8'hBD: m = {2'b11, s[5:0]};
          default: m = 8'h00;
        endcase
      end
      ROW_C4: begin
        case (s)
          8'h82: m = 8'hC3; 8'h83: m = 8'hE3; 8'h84: m = 8'hA5; 8'h85: m = 8'hB9;
          8'h86: m = 8'hC6; 8'h87: m = 8'hE6; 8'h8C: m = 8'hC8; 8'h8D: m = 8'hE8;
          8'h8E: m = 8'hCF; 8'h8F: m = 8'hEF; 8'h90: m = 8'hD0; 8'h91: m = 8'hF0;
          8'h98: m = 8'hCA; 8'h99: m = 8'hEA; 8'h9A: m = 8'hCC; 8'h9B: m = 8'hEC;
          8'hB9: m = 8'hC5; 8'hBA: m = 8'hE5; 8'hBD: m = 8'hBC; 8'hBE: m = 8'hBE;
          default: m = 8'h00;
        endcase
      end
      ROW_C5: begin
        case (s)
          8'h81: m = 8'hA3; 8'h82: m = 8'hB3; 8'h83: m = 8'hD1; 8'h84: m = 8'hF1;
          8'h87: m = 8'hD2; 8'h88: m = 8'hF2; 8'h90: m = 8'hD5; 8'h91: m = 8'hF5;
          8'h94: m = 8'hC0; 8'h95: m = 8'hE0; 8'h98: m = 8'hD8; 8'h99: m = 8'hF8;
          8'h9A: m = 8'h8C; 8'h9B: m = 8'h9C; 8'h9E: m = 8'hAA; 8'h9F: m = 8'hBA;
          8'hA0: m = 8'h8A; 8'hA1: m = 8'h9A; 8'hA2: m = 8'hDE; 8'hA3: m = 8'hFE;
          8'hA4: m = 8'h8D; 8'hA5: m = 8'h9D; 8'hAE: m = 8'hD9; 8'hAF: m = 8'hF9;
          8'hB0: m = 8'hDB; 8'hB1: m = 8'hFB; 8'hB9: m = 8'h8F; 8'hBA: m = 8'h9F;
          8'hBB: m = 8'hAF; 8'hBC: m = 8'hBF; 8'hBD: m = 8'h8E; 8'hBE: m = 8'h9E;
          default: m = 8'h00;
        endcase
      end
      ROW_CB: begin
        case (s)
          8'h87: m = 8'hA1; 8'h98: m = 8'hA2; 8'h99: m = 8'hFF; 8'h9B: m = 8'hB2;
          8'h9D: m = 8'hBD;
          default: m = 8'h00;
        endcase
      end
      ROW_E2_80: begin
        case (s)
          8'h93: m = 8'h96; 8'h94: m = 8'h97; 8'h98: m = 8'h91; 8'h99: m = 8'h92;
          8'h9A: m = 8'h82; 8'h9C: m = 8'h93; 8'h9D: m = 8'h94; 8'h9E: m = 8'h84;
          8'hA0: m = 8'h86; 8'hA1: m = 8'h87; 8'hA2: m = 8'h95; 8'hA6: m = 8'h85;
          8'hB0: m = 8'h89; 8'hB9: m = 8'h8B; 8'hBA: m = 8'h9B;
          default: m = 8'h00;
        endcase
      end
      ROW_E2_82: m = (s == 8'hAC) ? 8'h80 : 8'h00;
      ROW_E2_84: m = (s == 8'hA2) ? 8'h99 : 8'h00;
      ROW_C8:    m = (s == 8'h9A) ? 8'hDE : 8'h00;
      default:   m = 8'h00;
    endcase
    cp_map = m;
  endfunction

endpackage

// File: hdl/utf8_to_cp1250_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_cp1250_transcoder_top
// Converts a zero-terminated UTF-8 byte stream into Windows-1250 bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_byte) takes one UTF-8 byte per
// transfer. The output channel (out_valid, out_ready, out_byte,
// out_end_of_string, out_stop_reason) gives zero or one CP1250 byte for each
// input byte; the terminating zero carries out_end_of_string and the reason.
// cfg_we with cfg_max_chars sets the character limit; write it only while idle.
// An accepted byte addresses the mapping ROM in the cycle of its transfer;
// the ROM word is registered, the resolve stage then settles the sequence
// state and the result lands in the output register. One byte is taken
// every cycle while the receiver keeps up. The ROM is addressed by the
// previous byte and the new one only, so its read never waits on the
// sequence state.
// If the receiver stalls with a result waiting, the resolve stage holds its
// byte and in_ready drops once that stage is full as well.
// Reset (rst_n low, synchronous) empties the pipeline, drops any buffered
// sequence, clears the character count and sets the limit to 255.
// ----------------------------------------------------------------------------
`include "utf8_to_cp1250_transcoder_top_macros.svh"

module utf8_to_cp1250_transcoder_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_max_chars,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_end_of_string,
  output logic [1:0]  out_stop_reason
);

  // Width for comparing the count with the limit.
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [CMP_W-1:0] CMAX = CMP_W'((33'd1 << COUNT_BITS) - 33'd1);

  logic [15:0]           max_chars_r;

  // Lookup stage: the byte and its registered ROM word.
  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic [7:0]            rom_q_r;
  logic [7:0]            prev_byte_r;

  // Sequence state.
  logic [7:0]            lead_first_r, lead_first_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] char_count_r, char_count_nxt;
  logic                  disc_r, disc_nxt;

  // Output register.
  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_eos_r;
  logic [1:0]            out_reason_r;

  logic                  s2_go;
  logic                  in_xfer;
  logic                  do_char;
  logic [7:0]            char_val;
  logic                  do_term;
  logic [1:0]            term_reason;
  logic                  term_skip;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic                  emit_last;
  logic [1:0]            emit_reason;
  logic [CMP_W-1:0]      max_ext;
  logic [CMP_W-1:0]      lim;
  logic [CMP_W-1:0]      count_ext;

  // The resolve stage moves only when the output register can take a result.
  assign s2_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_go;
  assign in_xfer  = in_valid && in_ready;

  assign max_ext   = CMP_W'(max_chars_r);
  assign lim       = (max_ext > CMAX) ? CMAX : max_ext;
  assign count_ext = CMP_W'(char_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= 16'd255;
    end else if (cfg_we) begin
      max_chars_r <= cfg_max_chars;
    end
  end

  // Mapping ROM with a registered read. The last byte of a pending sequence is
  // always the byte transferred just before, so that byte selects the table row.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rom_q_r     <= u2c_pkg::cp_map(u2c_pkg::row_of(prev_byte_r), in_byte);
      s1_byte_r   <= in_byte;
      prev_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s2_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Sequence decision for the byte in the resolve stage.
  always_comb begin
    lead_first_nxt = lead_first_r;
    pend_nxt       = pend_r;
    disc_nxt       = disc_r;
    char_count_nxt = char_count_r;
    do_char        = 1'b0;
    char_val       = rom_q_r;
    do_term        = 1'b0;
    term_reason    = u2c_pkg::STOP_INPUT_ZERO;
    term_skip      = 1'b0;
    emit           = 1'b0;
    emit_byte      = 8'h00;
    emit_last      = 1'b0;
    emit_reason    = u2c_pkg::STOP_INPUT_ZERO;

    if (s2_go) begin
      if (disc_r) begin
        // Skip everything up to and including the next input zero.
        if (s1_byte_r == 8'h00) begin
          disc_nxt       = 1'b0;
          char_count_nxt = '0;
        end
      end else begin
        case (pend_r)
          u2c_pkg::PEND_LEAD: begin
            if (lead_first_r == u2c_pkg::LEAD_E2) begin
              if (u2c_pkg::middle_ok(s1_byte_r)) begin
                pend_nxt = u2c_pkg::PEND_MID;
              end else begin
                do_term     = 1'b1;
                term_reason = u2c_pkg::STOP_UNMAPPED;
                term_skip   = (s1_byte_r != 8'h00);
              end
            end else begin
              pend_nxt = u2c_pkg::PEND_NONE;
              if (rom_q_r != 8'h00) begin
                do_char = 1'b1;
              end else begin
                do_term     = 1'b1;
                term_reason = u2c_pkg::STOP_UNMAPPED;
                term_skip   = (s1_byte_r != 8'h00);
              end
            end
          end
          u2c_pkg::PEND_MID: begin
            pend_nxt = u2c_pkg::PEND_NONE;
            if (rom_q_r != 8'h00) begin
              do_char = 1'b1;
            end else begin
              do_term     = 1'b1;
              term_reason = u2c_pkg::STOP_UNMAPPED;
              term_skip   = (s1_byte_r != 8'h00);
            end
          end
          default: begin
            pend_nxt = u2c_pkg::PEND_NONE;
            if (s1_byte_r == 8'h00) begin
              do_term     = 1'b1;
              term_reason = u2c_pkg::STOP_INPUT_ZERO;
            end else if (u2c_pkg::is_lead(s1_byte_r)) begin
              lead_first_nxt = s1_byte_r;
              pend_nxt       = u2c_pkg::PEND_LEAD;
            end else begin
              do_char  = 1'b1;
              char_val = s1_byte_r;
            end
          end
        endcase

        // A character beyond the limit becomes a cut terminator.
        if (do_char) begin
          if (count_ext >= lim) begin
            do_term     = 1'b1;
            term_reason = u2c_pkg::STOP_LIMIT;
            term_skip   = 1'b1;
          end else begin
            char_count_nxt = char_count_r + COUNT_BITS'(1);
            emit           = 1'b1;
            emit_byte      = char_val;
          end
        end

        if (do_term) begin
          char_count_nxt = '0;
          pend_nxt       = u2c_pkg::PEND_NONE;
          disc_nxt       = term_skip;
          emit           = 1'b1;
          emit_byte      = 8'h00;
          emit_last      = 1'b1;
          emit_reason    = term_reason;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= u2c_pkg::PEND_NONE;
      char_count_r <= '0;
      disc_r       <= 1'b0;
      lead_first_r <= 8'h00;
    end else begin
      pend_r       <= pend_nxt;
      char_count_r <= char_count_nxt;
      disc_r       <= disc_nxt;
      lead_first_r <= lead_first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && emit) begin
      out_byte_r   <= emit_byte;
      out_eos_r    <= emit_last;
      out_reason_r <= emit_reason;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_end_of_string = out_eos_r;
  assign out_stop_reason   = out_reason_r;

  // An ordinary character is never zero and carries no stop reason.
  `U2C_ASSERT_SAME(a_char_nonzero, out_valid_r && !out_eos_r, out_byte_r != 8'h00 && out_reason_r == u2c_pkg::STOP_INPUT_ZERO, "ordinary character is zero or has a reason")

  // The count never runs past the limit.
  `U2C_ASSERT_SAME(a_count_in_limit, 1'b1, count_ext <= lim, "character count exceeds limit")

  // No sequence is buffered while skipping to the input zero.
  `U2C_ASSERT_SAME(a_disc_no_pend, disc_r, pend_r == u2c_pkg::PEND_NONE, "sequence pending while discarding")

  // A held resolve stage keeps its byte.
  `U2C_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s2_go, s1_valid_r && $stable(s1_byte_r), "resolve stage lost its byte under stall")

endmodule
